@@ src/mdtr_pkg.sv @@
// ---------------------------------------------------------------------------
// mdtr_pkg
// Shared types and constants of the MIDI delta-time retimer.
// ---------------------------------------------------------------------------
package mdtr_pkg;

  // Width of the largest scaled delta that fits a 4-byte variable-length quantity
  localparam int unsigned LimitBits = 28;
  localparam int unsigned GroupBits = 7;

  // Configuration register index (paddr bit 2)
  localparam logic REG_SOURCE_CLOCK = 1'b0;
  localparam logic REG_TARGET_CLOCK = 1'b1;

  // High nibbles of status bytes
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_CONTROL   = 4'hB;
  localparam logic [3:0] NIB_END       = 4'hF;
  localparam logic [3:0] NIB_UNKNOWN_A = 4'hA;
  localparam logic [3:0] NIB_UNKNOWN_D = 4'hD;
  localparam logic [3:0] NIB_UNKNOWN_E = 4'hE;

  typedef enum logic [1:0] {
    PH_DELTA  = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

endpackage

@@ src/midi_delta_time_retimer.sv @@
// ---------------------------------------------------------------------------
// midi_delta_time_retimer
// Retimes the delta times of a MIDI music section: decodes each VLQ delta,
// scales it by target_clock / source_clock and re-encodes it; status and
// data bytes pass through.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | sink      | in_valid_i / in_stall_o   | in_byte_i, start_of_stream_i
//  out      | source    | out_valid_o / out_stall_i | out_byte_o, last_of_run_o,
//           |           |                           | error_*_o, finished_o
//  config   | sink      | APB (psel/penable/pready) | source_clock, target_clock
//
// A byte is registered on transfer in and decoded in S_STEP. A pass-through byte
// is then loaded into the output register in S_PASS once that register is free.
// The final byte of a delta runs a bit-serial multiply (one target_clock bit
// per cycle), a restoring divide (one quotient bit per cycle), a check step
// and one cycle per encoded byte while the output is not stalled.
// Reset clears the parser and sets both clocks to 96. A stall on the output
// holds the block once the output register is full; the next byte is taken
// while the last result still waits.
module midi_delta_time_retimer
  import mdtr_pkg::*;
#(
  parameter int unsigned DELTA_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        start_of_stream_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        error_unknown_code_o,
  output logic        error_overflow_o,
  output logic        finished_o,

  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned ProdBits = DELTA_BITS + 16;
  localparam int unsigned CntBits  = $clog2(ProdBits);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_DIV,
    S_CHECK,
    S_EMIT,
    S_PASS
  } state_e;

  // Configuration
  logic [15:0] src_clk_q, tgt_clk_q;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_TARGET_CLOCK) ? {16'b0, tgt_clk_q} : {16'b0, src_clk_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clk_q <= 16'd96;
      tgt_clk_q <= 16'd96;
    end else if (psel_i && penable_i && pwrite_i) begin
      if (paddr_i[2] == REG_SOURCE_CLOCK) begin
        src_clk_q <= pwdata_i[15:0];
      end else begin
        tgt_clk_q <= pwdata_i[15:0];
      end
    end
  end

  // Parser and datapath state
  state_e                  state_q, state_d;
  phase_e                  phase_q, phase_d;
  logic [1:0]              left_q, left_d;
  logic [DELTA_BITS-1:0]   acc_q, acc_d;
  logic                    end_q, end_d;
  logic                    unk_q, unk_d;
  logic                    ovf_q, ovf_d;
  logic                    stop_q, stop_d;

  logic [7:0]              byte_q, byte_d;
  logic                    sos_q, sos_d;
  logic [DELTA_BITS-1:0]   mcand_q, mcand_d;
  logic [15:0]             tsr_q, tsr_d;
  logic [ProdBits-1:0]     prod_q, prod_d;
  logic [15:0]             rem_q, rem_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [LimitBits-1:0]    esr_q, esr_d;
  logic [2:0]              ecnt_q, ecnt_d;

  logic                    ovalid_q, ovalid_d;
  logic [7:0]              obyte_q, obyte_d;
  logic                    olast_q, olast_d;
  logic                    ounk_q, ounk_d;
  logic                    oovf_q, oovf_d;
  logic                    ofin_q, ofin_d;

  // Effective state after an optional start-of-stream clear
  phase_e                  c_phase;
  logic [1:0]              c_left;
  logic [DELTA_BITS-1:0]   c_acc;
  logic                    c_end, c_unk, c_ovf, c_stop;

  logic [DELTA_BITS+6:0]   acc_shift;
  logic [DELTA_BITS-1:0]   acc_new;
  logic                    ovf_now;
  logic                    out_free;
  logic                    in_xfer;
  logic [16:0]             div_r;
  logic                    div_ge;
  logic [ProdBits+27:0]    q_ext;
  logic [LimitBits-1:0]    q_lim;
  logic                    q_over;
  logic [3:0]              nib;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !ovalid_q || !out_stall_i;

  assign c_phase = sos_q ? PH_DELTA : phase_q;
  assign c_left  = sos_q ? 2'd0 : left_q;
  assign c_acc   = sos_q ? '0 : acc_q;
  assign c_end   = sos_q ? 1'b0 : end_q;
  assign c_unk   = sos_q ? 1'b0 : unk_q;
  assign c_ovf   = sos_q ? 1'b0 : ovf_q;
  assign c_stop  = sos_q ? 1'b0 : stop_q;

  assign acc_shift = {c_acc, byte_q[6:0]};
  assign acc_new   = acc_shift[DELTA_BITS-1:0];
  assign ovf_now   = (c_acc >> (DELTA_BITS - 7)) != '0;
  assign nib       = byte_q[7:4];

  assign div_r  = {rem_q, prod_q[ProdBits-1]};
  assign div_ge = div_r >= {1'b0, src_clk_q};

  assign q_ext  = {28'b0, prod_q};
  assign q_lim  = q_ext[LimitBits-1:0];
  assign q_over = (q_ext >> LimitBits) != '0;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    left_d   = left_q;
    acc_d    = acc_q;
    end_d    = end_q;
    unk_d    = unk_q;
    ovf_d    = ovf_q;
    stop_d   = stop_q;
    byte_d   = byte_q;
    sos_d    = sos_q;
    mcand_d  = mcand_q;
    tsr_d    = tsr_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    esr_d    = esr_q;
    ecnt_d   = ecnt_q;
    ovalid_d = ovalid_q && out_stall_i;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ounk_d   = ounk_q;
    oovf_d   = oovf_q;
    ofin_d   = ofin_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          byte_d  = in_byte_i;
          sos_d   = start_of_stream_i;
          state_d = S_STEP;
        end
      end

      S_STEP: begin
        phase_d = c_phase;
        left_d  = c_left;
        acc_d   = c_acc;
        end_d   = c_end;
        unk_d   = c_unk;
        ovf_d   = c_ovf;
        stop_d  = c_stop;
        state_d = S_IDLE;
        if (!c_stop) begin
          if (c_phase == PH_DELTA) begin
            ovf_d = c_ovf || ovf_now;
            acc_d = acc_new;
            if (!byte_q[7]) begin
              acc_d   = '0;
              phase_d = PH_STATUS;
              if (!ovf_d) begin
                if (src_clk_q == '0) begin
                  ovf_d = 1'b1;
                end else begin
                  mcand_d = acc_new;
                  tsr_d   = tgt_clk_q;
                  prod_d  = '0;
                  cnt_d   = CntBits'(15);
                  state_d = S_MUL;
                end
              end
            end
          end else if (c_phase == PH_DATA && c_left != 2'd0) begin
            left_d  = c_left - 2'd1;
            state_d = S_PASS;
            if (c_left == 2'd1) begin
              phase_d = PH_DELTA;
              if (c_end || c_unk || c_ovf) begin
                stop_d = 1'b1;
              end
            end
          end else begin
            phase_d = PH_DATA;
            state_d = S_PASS;
            case (nib)
              NIB_END: begin
                end_d  = 1'b1;
                left_d = 2'd2;
              end
              NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CONTROL: left_d = 2'd2;
              NIB_UNKNOWN_A, NIB_UNKNOWN_D, NIB_UNKNOWN_E: begin
                unk_d  = 1'b1;
                left_d = 2'd1;
              end
              default: left_d = 2'd1;
            endcase
          end
        end
      end

      // Shift-add, most significant multiplier bit first
      S_MUL: begin
        prod_d = {prod_q[ProdBits-2:0], 1'b0}
               + (tsr_q[15] ? ProdBits'(mcand_q) : '0);
        tsr_d  = {tsr_q[14:0], 1'b0};
        cnt_d  = cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CntBits'(ProdBits - 1);
          state_d = S_DIV;
        end
      end

      // Restoring divide: quotient bits shift in where the dividend leaves
      S_DIV: begin
        rem_d  = div_ge ? 16'(div_r - {1'b0, src_clk_q}) : div_r[15:0];
        prod_d = {prod_q[ProdBits-2:0], div_ge};
        cnt_d  = cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (q_over) begin
          ovf_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_EMIT;
          // left-align the significant groups
          if (q_lim[27:21] != '0) begin
            ecnt_d = 3'd4;
            esr_d  = q_lim;
          end else if (q_lim[20:14] != '0) begin
            ecnt_d = 3'd3;
            esr_d  = {q_lim[20:0], 7'b0};
          end else if (q_lim[13:7] != '0) begin
            ecnt_d = 3'd2;
            esr_d  = {q_lim[13:0], 14'b0};
          end else begin
            ecnt_d = 3'd1;
            esr_d  = {q_lim[6:0], 21'b0};
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = {ecnt_q != 3'd1, esr_q[27:21]};
          olast_d  = (ecnt_q == 3'd1);
          ounk_d   = unk_q;
          oovf_d   = ovf_q;
          ofin_d   = stop_q;
          esr_d    = {esr_q[20:0], 7'b0};
          ecnt_d   = ecnt_q - 3'd1;
          if (ecnt_q == 3'd1) begin
            state_d = S_IDLE;
          end
        end
      end

      S_PASS: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = byte_q;
          olast_d  = 1'b1;
          ounk_d   = unk_q;
          oovf_d   = ovf_q;
          ofin_d   = stop_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_DELTA;
      left_q   <= '0;
      acc_q    <= '0;
      end_q    <= 1'b0;
      unk_q    <= 1'b0;
      ovf_q    <= 1'b0;
      stop_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      end_q    <= end_d;
      unk_q    <= unk_d;
      ovf_q    <= ovf_d;
      stop_q   <= stop_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    sos_q   <= sos_d;
    mcand_q <= mcand_d;
    tsr_q   <= tsr_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    esr_q   <= esr_d;
    ecnt_q  <= ecnt_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ounk_q  <= ounk_d;
    oovf_q  <= oovf_d;
    ofin_q  <= ofin_d;
  end

  assign out_valid_o          = ovalid_q;
  assign out_byte_o           = obyte_q;
  assign last_of_run_o        = olast_q;
  assign error_unknown_code_o = ounk_q;
  assign error_overflow_o     = oovf_q;
  assign finished_o           = ofin_q;

endmodule
